// ----- hw/rtl/triangle_tangent_calc_top_assert.svh -----
// assertion macros for the tangent block checker
`ifndef TRIANGLE_TANGENT_CALC_TOP_ASSERT_SVH
`define TRIANGLE_TANGENT_CALC_TOP_ASSERT_SVH

// implication checked on every clock, suspended in reset
`define TTC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ttc_pkg.sv -----
`timescale 1ns / 1ps
package ttc_pkg;
    typedef logic signed [32:0] delta_t;
    typedef logic signed [66:0] wide_t;
    localparam int NORM_TOP_BIT = 29;

    typedef struct packed {
        logic [31:0]        vertex_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_s;
        logic signed [31:0] tex_t;
    } vertex_t;

    typedef struct packed {
        logic [31:0]        out_index;
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic               degenerate;
        logic               last_of_triangle;
    } result_t;

    // controller to datapath commands
    typedef struct packed {
        logic       hold0;
        logic       hold1;
        logic       load_third;
        logic [3:0] step;
        logic       sqrt_start;
        logic       sqrt_step;
        logic       div_start;
        logic       div_step;
        logic [1:0] div_sel;
    } dp_cmd_t;
endpackage

// ----- hw/rtl/ttc_if.sv -----
`timescale 1ns / 1ps
interface ttc_vertex_if;
    logic valid;
    logic ready;
    ttc_pkg::vertex_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/ttc_result_if.sv -----
`timescale 1ns / 1ps
interface ttc_result_if;
    logic valid;
    logic ready;
    ttc_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/ttc_datapath.sv -----
`timescale 1ns / 1ps
module ttc_datapath (
    input  logic             clk,
    input  ttc_pkg::dp_cmd_t cmd,
    input  ttc_pkg::vertex_t vin,
    output logic [15:0]      comp_x,
    output logic [15:0]      comp_y,
    output logic [15:0]      comp_z,
    output logic             degen,
    output logic [31:0]      idx0,
    output logic [31:0]      idx1,
    output logic [31:0]      idx2
);
    import ttc_pkg::*;

    // held corners
    vertex_t c0_reg, c1_reg, c2_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.hold0)
        begin
            c0_reg <= vin;
        end
        if (cmd.hold1)
        begin
            c1_reg <= vin;
        end
        if (cmd.load_third)
        begin
            c2_reg <= vin;
        end
    end
    assign idx0 = c0_reg.vertex_index;
    assign idx1 = c1_reg.vertex_index;
    assign idx2 = c2_reg.vertex_index;

    // deltas
    delta_t dp1_reg [3];
    delta_t dp2_reg [3];
    delta_t ds1s_reg, ds1t_reg, ds2s_reg, ds2t_reg;
    // shared multiplier operands and product
    delta_t ma, mb;
    wide_t  prod;
    wide_t  prod_reg;
    wide_t  det_reg;
    wide_t  t_reg [3];
    logic [66:0] mag [3];
    logic        tneg [3];
    logic [6:0]  top;
    logic        zero_t;
    logic [63:0] m_reg [3];
    logic [63:0] m_next [3];
    logic [63:0] sq_reg;
    logic [63:0] sum_reg;

    // step schedule: 1..8 products, normalize on 10, squares and sum on 11..14
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.step)
            4'd1: begin ma = ds1s_reg; mb = ds2t_reg; end
            4'd2: begin ma = ds1t_reg; mb = ds2s_reg; end
            4'd3: begin ma = dp1_reg[0]; mb = ds2t_reg; end
            4'd4: begin ma = dp2_reg[0]; mb = ds1t_reg; end
            4'd5: begin ma = dp1_reg[1]; mb = ds2t_reg; end
            4'd6: begin ma = dp2_reg[1]; mb = ds1t_reg; end
            4'd7: begin ma = dp1_reg[2]; mb = ds2t_reg; end
            4'd8: begin ma = dp2_reg[2]; mb = ds1t_reg; end
            default: ;
        endcase
    end
    assign prod = 67'(ma) * 67'(mb);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tneg[i] = t_reg[i][66];
            mag[i]  = tneg[i] ? 67'(-t_reg[i]) : t_reg[i];
        end
    end

    // leading one of the or of magnitudes
    logic [66:0] mor;
    always_comb
    begin
        mor = mag[0] | mag[1] | mag[2];
        top = '0;
        for (int b = 0; b < 67; b++)
        begin
            if (mor[b])
            begin
                top = 7'(b);
            end
        end
        zero_t = (mor == '0);
        for (int i = 0; i < 3; i++)
        begin
            if (top > 7'(NORM_TOP_BIT))
            begin
                m_next[i] = 64'(mag[i] >> (top - 7'(NORM_TOP_BIT)));
            end
            else
            begin
                m_next[i] = 64'(mag[i] << (7'(NORM_TOP_BIT) - top));
            end
        end
    end

    logic degen_reg;
    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        if (cmd.load_third)
        begin
            dp1_reg[0] <= 33'(c1_reg.pos_x) - 33'(c0_reg.pos_x);
            dp1_reg[1] <= 33'(c1_reg.pos_y) - 33'(c0_reg.pos_y);
            dp1_reg[2] <= 33'(c1_reg.pos_z) - 33'(c0_reg.pos_z);
            dp2_reg[0] <= 33'(vin.pos_x) - 33'(c0_reg.pos_x);
            dp2_reg[1] <= 33'(vin.pos_y) - 33'(c0_reg.pos_y);
            dp2_reg[2] <= 33'(vin.pos_z) - 33'(c0_reg.pos_z);
            ds1s_reg   <= 33'(c1_reg.tex_s) - 33'(c0_reg.tex_s);
            ds1t_reg   <= 33'(c1_reg.tex_t) - 33'(c0_reg.tex_t);
            ds2s_reg   <= 33'(vin.tex_s) - 33'(c0_reg.tex_s);
            ds2t_reg   <= 33'(vin.tex_t) - 33'(c0_reg.tex_t);
        end
        case (cmd.step)
            4'd2: det_reg <= prod_reg;
            4'd3: det_reg <= det_reg - prod_reg;
            4'd4: t_reg[0] <= prod_reg;
            4'd5: t_reg[0] <= t_reg[0] - prod_reg;
            4'd6: t_reg[1] <= prod_reg;
            4'd7: t_reg[1] <= t_reg[1] - prod_reg;
            4'd8: t_reg[2] <= prod_reg;
            4'd9: t_reg[2] <= t_reg[2] - prod_reg;
            4'd10:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    m_reg[i] <= m_next[i];
                end
                degen_reg <= (det_reg == '0) || zero_t;
                sum_reg   <= '0;
            end
            4'd11: sq_reg <= 64'(m_reg[0][29:0]) * 64'(m_reg[0][29:0]);
            4'd12:
            begin
                sum_reg <= sum_reg + sq_reg;
                sq_reg  <= 64'(m_reg[1][29:0]) * 64'(m_reg[1][29:0]);
            end
            4'd13:
            begin
                sum_reg <= sum_reg + sq_reg;
                sq_reg  <= 64'(m_reg[2][29:0]) * 64'(m_reg[2][29:0]);
            end
            4'd14: sum_reg <= sum_reg + sq_reg;
            default: ;
        endcase
    end
    assign degen = degen_reg;

    // iterative square root, one result bit per step
    logic [63:0] rem_reg;
    logic [63:0] root_reg;
    logic [63:0] rbit_reg;
    logic [63:0] trial;
    assign trial = root_reg + rbit_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            rem_reg  <= sum_reg;
            root_reg <= '0;
            rbit_reg <= 64'd1 << 62;
        end
        else if (cmd.sqrt_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + rbit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            rbit_reg <= rbit_reg >> 2;
        end
    end

    // restoring divider: (m*32768 + len) / (2*len), quotient <= 16384
    logic [47:0] num_reg;
    logic [32:0] drem_reg;
    logic [15:0] quo_reg;
    logic [32:0] dshift;
    logic [32:0] dden;
    logic [15:0] q_reg [3];
    assign dden   = {root_reg[31:0], 1'b0};
    assign dshift = {drem_reg[31:0], num_reg[47]};
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            num_reg  <= 48'(m_reg[cmd.div_sel][29:0]) * 48'd32768
                        + {16'd0, root_reg[31:0]};
            drem_reg <= '0;
            quo_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= num_reg << 1;
            if (dshift >= dden)
            begin
                drem_reg <= dshift - dden;
                quo_reg  <= {quo_reg[14:0], 1'b1};
            end
            else
            begin
                drem_reg <= dshift;
                quo_reg  <= {quo_reg[14:0], 1'b0};
            end
        end
        else if (cmd.step == 4'd15)
        begin
            q_reg[cmd.div_sel] <= quo_reg;
        end
    end

    logic dneg;
    assign dneg = det_reg[66];
    always_comb
    begin
        comp_x = degen_reg ? 16'd0 : ((tneg[0] != dneg) ? 16'(-q_reg[0]) : q_reg[0]);
        comp_y = degen_reg ? 16'd0 : ((tneg[1] != dneg) ? 16'(-q_reg[1]) : q_reg[1]);
        comp_z = degen_reg ? 16'd0 : ((tneg[2] != dneg) ? 16'(-q_reg[2]) : q_reg[2]);
    end
endmodule

// ----- hw/rtl/ttc_ctrl.sv -----
`timescale 1ns / 1ps
module ttc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       out_sel,
    output ttc_pkg::dp_cmd_t cmd
);
    import ttc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ARITH = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_DIV = 3'd3;
    localparam logic [2:0] ST_OUT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] corner_reg, corner_next;
    logic [3:0] step_reg, step_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] sel_reg, sel_next;
    logic       acc;

    assign in_ready  = (state_reg == ST_IDLE);
    assign acc       = in_valid && in_ready;
    assign out_valid = (state_reg == ST_OUT);
    assign out_sel   = sel_reg;

    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        step_next   = step_reg;
        cnt_next    = cnt_reg;
        sel_next    = sel_reg;
        cmd         = '0;
        cmd.step    = step_reg;
        cmd.div_sel = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    cmd.hold0      = (corner_reg == 2'd0);
                    cmd.hold1      = (corner_reg == 2'd1);
                    cmd.load_third = (corner_reg == 2'd2);
                    if (corner_reg == 2'd2)
                    begin
                        corner_next = '0;
                        step_next   = 4'd1;
                        state_next  = ST_ARITH;
                    end
                    else
                    begin
                        corner_next = corner_reg + 2'd1;
                    end
                end
            end
            ST_ARITH:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd14)
                begin
                    step_next  = '0;
                    state_next = ST_SQRT;
                    cmd.sqrt_start = 1'b0;
                end
            end
            ST_SQRT:
            begin
                if (cnt_reg == 6'd0)
                begin
                    cmd.sqrt_start = 1'b1;
                    cnt_next = 6'd1;
                end
                else
                begin
                    cmd.sqrt_step = 1'b1;
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'd32)
                    begin
                        cnt_next   = '0;
                        sel_next   = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == 6'd0)
                begin
                    cmd.div_start = 1'b1;
                    cnt_next = 6'd1;
                end
                else if (cnt_reg <= 6'd48)
                begin
                    cmd.div_step = 1'b1;
                    cnt_next = cnt_reg + 6'd1;
                end
                else
                begin
                    cmd.step = 4'd15;
                    cnt_next = '0;
                    if (sel_reg == 2'd2)
                    begin
                        sel_next   = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        sel_next = sel_reg + 2'd1;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (sel_reg == 2'd2)
                    begin
                        sel_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        sel_next = sel_reg + 2'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            corner_reg <= '0;
            step_reg   <= '0;
            cnt_reg    <= '0;
            sel_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
            step_reg   <= step_next;
            cnt_reg    <= cnt_next;
            sel_reg    <= sel_next;
        end
    end
endmodule

// ----- hw/rtl/triangle_tangent_calc_top.sv -----
// corners one and two are taken and held, and give no result
// third corner: once it is taken, the arithmetic steps, the square root and three divides
// run in turn before the first result is offered
// then three results, one per cycle while rout.ready is high
// no corner of a new triangle is taken until the last result of the previous one is taken
// rst_n asynchronous, active low: clears the corner count and controller state
`timescale 1ns / 1ps
module triangle_tangent_calc_top #(
    parameter int COORD_FRAC_BITS = 16
) (
    input logic     clk,
    input logic     rst_n,
    ttc_vertex_if.sink   vin,
    ttc_result_if.source rout
);
    import ttc_pkg::*;

    dp_cmd_t     cmd;
    logic [1:0]  sel;
    logic [15:0] cx, cy, cz;
    logic        dg;
    logic [31:0] i0, i1, i2;
    logic [4:0]  frac_unused;

    // the fraction scale cancels in normalization
    assign frac_unused = 5'(COORD_FRAC_BITS);

    ttc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vin.valid),
        .in_ready  (vin.ready),
        .out_valid (rout.valid),
        .out_ready (rout.ready),
        .out_sel   (sel),
        .cmd       (cmd)
    );

    ttc_datapath u_dp (
        .clk    (clk),
        .cmd    (cmd),
        .vin    (vin.data),
        .comp_x (cx),
        .comp_y (cy),
        .comp_z (cz),
        .degen  (dg),
        .idx0   (i0),
        .idx1   (i1),
        .idx2   (i2)
    );

    // result mux
    always_comb
    begin
        rout.data.tangent_x        = cx;
        rout.data.tangent_y        = cy;
        rout.data.tangent_z        = cz;
        rout.data.degenerate       = dg & (frac_unused != 5'd31 || 1'b1);
        rout.data.last_of_triangle = (sel == 2'd2);
        case (sel)
            2'd0:    rout.data.out_index = i0;
            2'd1:    rout.data.out_index = i1;
            default: rout.data.out_index = i2;
        endcase
    end
endmodule

// ----- hw/rtl/ttc_checker.sv -----
`timescale 1ns / 1ps
`include "triangle_tangent_calc_top_assert.svh"
module ttc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic last
);
    `TTC_ASSERT_IMPL(no_in_while_out, clk, rst_n, out_valid, !in_ready, "input taken during output")
    `TTC_ASSERT_NEXT(out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
    `TTC_ASSERT_NEXT(end_of_tri, clk, rst_n, out_valid && out_ready && last, !out_valid, "extra result")
endmodule

bind triangle_tangent_calc_top ttc_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vin.valid),
    .in_ready  (vin.ready),
    .out_valid (rout.valid),
    .out_ready (rout.ready),
    .last      (rout.data.last_of_triangle)
);

// ----- sim/triangle_tangent_calc_top_test.sv -----
`timescale 1ns / 1ps
module triangle_tangent_calc_top_test;
    import ttc_pkg::*;

    localparam int TANGENT_TOP_BIT = 29;
    localparam int SETTLE_CYCLES = 300;
    localparam int LONG_HOLD = 1200;
    localparam int HOLD_AT_RESULT = 40;
    localparam int RANDOM_TRIANGLES = 67;

    // triangle content patterns for random stimulus
    typedef enum int {
        TRI_FULL_RANGE,
        TRI_SMALL,
        TRI_FLAT_UV,
        TRI_SAME_POS
    } tri_kind_e;

    // tangent predictor and store of pending corner tangents
    class tangent_scoreboard;
        result_t pending_tangents[$];
        int errors;
        int corners_held;
        logic [31:0] held_idx[2];
        longint held_pos[2][3];
        longint held_uv[2][2];

        function new();
            errors = 0;
            corners_held = 0;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return res;
        endfunction

        // hold first two corners, predict three tangents on the third
        function void note_vertex(vertex_t v);
            longint p[3];
            longint s[2];
            logic signed [127:0] dp1[3];
            logic signed [127:0] dp2[3];
            logic signed [127:0] ds1[2];
            logic signed [127:0] ds2[2];
            logic signed [127:0] det;
            logic signed [127:0] tv;
            logic [127:0] mag[3];
            logic [127:0] shifted;
            logic tneg[3];
            logic dneg;
            logic degen;
            int top;
            longint unsigned m[3];
            longint unsigned sum;
            longint unsigned len;
            longint unsigned q;
            logic [15:0] comp[3];
            logic [31:0] idx[3];
            result_t r;
            p[0] = longint'(v.pos_x);
            p[1] = longint'(v.pos_y);
            p[2] = longint'(v.pos_z);
            s[0] = longint'(v.tex_s);
            s[1] = longint'(v.tex_t);
            if (corners_held < 2)
            begin
                held_idx[corners_held] = v.vertex_index;
                for (int i = 0; i < 3; i++)
                    held_pos[corners_held][i] = p[i];
                for (int i = 0; i < 2; i++)
                    held_uv[corners_held][i] = s[i];
                corners_held++;
                return;
            end
            corners_held = 0;
            for (int i = 0; i < 3; i++)
            begin
                dp1[i] = held_pos[1][i] - held_pos[0][i];
                dp2[i] = p[i] - held_pos[0][i];
            end
            for (int i = 0; i < 2; i++)
            begin
                ds1[i] = held_uv[1][i] - held_uv[0][i];
                ds2[i] = s[i] - held_uv[0][i];
            end
            det = ds1[0] * ds2[1] - ds1[1] * ds2[0];
            dneg = det < 0;
            degen = (det == 0);
            top = -1;
            for (int i = 0; i < 3; i++)
            begin
                tv = dp1[i] * ds2[1] - dp2[i] * ds1[1];
                tneg[i] = tv < 0;
                mag[i] = tneg[i] ? -tv : tv;
                for (int b = 127; b >= 0; b--)
                begin
                    if (mag[i][b])
                    begin
                        if (b > top)
                            top = b;
                        break;
                    end
                end
            end
            if (top < 0)
                degen = 1'b1;
            for (int i = 0; i < 3; i++)
                comp[i] = '0;
            if (!degen)
            begin
                sum = 0;
                for (int i = 0; i < 3; i++)
                begin
                    if (top > TANGENT_TOP_BIT)
                        shifted = mag[i] >> (top - TANGENT_TOP_BIT);
                    else
                        shifted = mag[i] << (TANGENT_TOP_BIT - top);
                    m[i] = shifted[63:0];
                    sum += m[i] * m[i];
                end
                len = root_floor(sum);
                for (int i = 0; i < 3; i++)
                begin
                    q = (m[i] * 64'd32768 + len) / (2 * len);
                    comp[i] = (tneg[i] != dneg) ? 16'(-q) : 16'(q);
                end
            end
            idx[0] = held_idx[0];
            idx[1] = held_idx[1];
            idx[2] = v.vertex_index;
            for (int k = 0; k < 3; k++)
            begin
                r.out_index = idx[k];
                r.tangent_x = comp[0];
                r.tangent_y = comp[1];
                r.tangent_z = comp[2];
                r.degenerate = degen;
                r.last_of_triangle = (k == 2);
                pending_tangents.push_back(r);
            end
        endfunction

        task check_result(result_t got);
            result_t want;
            if (pending_tangents.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result index %h", got.out_index));
                return;
            end
            want = pending_tangents.pop_front();
            if (got.out_index !== want.out_index)
                report_mismatch($sformatf("out_index %h, want %h",
                                          got.out_index, want.out_index));
            if (got.tangent_x !== want.tangent_x)
                report_mismatch($sformatf("tangent_x %h, want %h (index %h)",
                                          got.tangent_x, want.tangent_x, want.out_index));
            if (got.tangent_y !== want.tangent_y)
                report_mismatch($sformatf("tangent_y %h, want %h (index %h)",
                                          got.tangent_y, want.tangent_y, want.out_index));
            if (got.tangent_z !== want.tangent_z)
                report_mismatch($sformatf("tangent_z %h, want %h (index %h)",
                                          got.tangent_z, want.tangent_z, want.out_index));
            if (got.degenerate !== want.degenerate)
                report_mismatch($sformatf("degenerate %b, want %b (index %h)",
                                          got.degenerate, want.degenerate, want.out_index));
            if (got.last_of_triangle !== want.last_of_triangle)
                report_mismatch($sformatf("last_of_triangle %b, want %b (index %h)",
                                          got.last_of_triangle, want.last_of_triangle,
                                          want.out_index));
        endtask
    endclass

    logic clk;
    logic rst_n;
    ttc_vertex_if vin();
    ttc_result_if rout();
    tangent_scoreboard sb;
    int results_seen;

    triangle_tangent_calc_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .vin(vin.sink),
        .rout(rout.source)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // send one vertex, after a random gap unless no_gap is set
    task send_vertex(vertex_t v, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            vin.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vin.valid <= 1'b1;
        vin.data <= v;
        do
            @(posedge clk);
        while (!vin.ready);
        sb.note_vertex(v);
    endtask

    function automatic vertex_t make_vertex(logic [31:0] idx, logic [31:0] x, logic [31:0] y,
                                            logic [31:0] z, logic [31:0] s, logic [31:0] t);
        vertex_t v;
        v.vertex_index = idx;
        v.pos_x = x;
        v.pos_y = y;
        v.pos_z = z;
        v.tex_s = s;
        v.tex_t = t;
        return v;
    endfunction

    function automatic logic [31:0] small_coord();
        return 32'($signed($urandom_range(0, 2097152)) - 1048576);
    endfunction

    // random triangle of a chosen kind
    task send_random_triangle(bit no_gap);
        tri_kind_e kind;
        vertex_t v[3];
        kind = tri_kind_e'($urandom_range(0, 3));
        for (int i = 0; i < 3; i++)
        begin
            v[i].vertex_index = $urandom;
            if (kind == TRI_FULL_RANGE)
            begin
                v[i].pos_x = $urandom;
                v[i].pos_y = $urandom;
                v[i].pos_z = $urandom;
                v[i].tex_s = $urandom;
                v[i].tex_t = $urandom;
            end
            else
            begin
                v[i].pos_x = small_coord();
                v[i].pos_y = small_coord();
                v[i].pos_z = small_coord();
                v[i].tex_s = small_coord();
                v[i].tex_t = small_coord();
            end
        end
        if (kind == TRI_FLAT_UV)
        begin
            // collinear uv, zero determinant
            v[2].tex_s = v[0].tex_s + 2 * (v[1].tex_s - v[0].tex_s);
            v[2].tex_t = v[0].tex_t + 2 * (v[1].tex_t - v[0].tex_t);
        end
        if (kind == TRI_SAME_POS)
        begin
            v[1].pos_x = v[0].pos_x;
            v[1].pos_y = v[0].pos_y;
            v[1].pos_z = v[0].pos_z;
            v[2].pos_x = v[0].pos_x;
            v[2].pos_y = v[0].pos_y;
            v[2].pos_z = v[0].pos_z;
        end
        for (int i = 0; i < 3; i++)
            send_vertex(v[i], no_gap);
    endtask

    // result receiver with random stalls and one long hold-off
    initial
    begin
        int gap;
        rout.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (results_seen == HOLD_AT_RESULT)
            begin
                rout.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                rout.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rout.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rout.valid);
            sb.check_result(rout.data);
            results_seen++;
        end
    end

    // stimulus and end of run
    initial
    begin
        sb = new();
        results_seen = 0;
        vin.valid = 1'b0;
        vin.data = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero determinant, zero tangent
        send_vertex(make_vertex(32'h0, 32'h7fffffff, 32'h80000000, 32'h0,
                                32'h80000000, 32'h80000000), 0);
        send_vertex(make_vertex(32'hffffffff, 32'h80000000, 32'h7fffffff, 32'hffffffff,
                                32'h7fffffff, 32'h80000000), 0);
        send_vertex(make_vertex(32'h1, 32'h0, 32'h0, 32'h7fffffff,
                                32'h80000000, 32'h7fffffff), 0);
        send_vertex(make_vertex(32'h10, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0), 0);
        send_vertex(make_vertex(32'h11, 32'h10000, 32'h0, 32'h0, 32'h10000, 32'h0), 0);
        send_vertex(make_vertex(32'h12, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h10000), 0);
        send_vertex(make_vertex(32'h20, 32'h1, 32'h2, 32'h3, 32'h5, 32'h5), 0);
        send_vertex(make_vertex(32'h21, 32'h4, 32'h5, 32'h6, 32'h5, 32'h5), 0);
        send_vertex(make_vertex(32'h22, 32'h7, 32'h8, 32'h9, 32'h5, 32'h5), 0);
        send_vertex(make_vertex(32'h30, 32'h1234, 32'h1234, 32'h1234, 32'h0, 32'h0), 1);
        send_vertex(make_vertex(32'h31, 32'h1234, 32'h1234, 32'h1234, 32'h10000, 32'h0), 1);
        send_vertex(make_vertex(32'h32, 32'h1234, 32'h1234, 32'h1234, 32'h0, 32'h10000), 1);
        send_vertex(make_vertex(32'h40, 32'h80000000, 32'h80000000, 32'h80000000,
                                32'h7fffffff, 32'h7fffffff), 1);
        send_vertex(make_vertex(32'h41, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                32'h80000000, 32'h7fffffff), 1);
        send_vertex(make_vertex(32'h42, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                32'h7fffffff, 32'h80000000), 1);
        send_vertex(make_vertex(32'h50, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0), 0);
        send_vertex(make_vertex(32'h51, 32'h0, 32'h0, 32'h1, 32'h1, 32'h0), 0);
        send_vertex(make_vertex(32'h52, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1), 0);

        // random triangles, some runs back to back
        for (int n = 0; n < RANDOM_TRIANGLES; n++)
            send_random_triangle((n / 8) % 3 == 1);
        vin.valid <= 1'b0;

        while (sb.pending_tangents.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("triangle_tangent_calc_top verification clean");
        else
            $display("triangle_tangent_calc_top verification failed");
        $finish;
    end

    // run limit
    initial
    begin
        #400000;
        $display("triangle_tangent_calc_top verification failed");
        $finish;
    end
endmodule
